// ===== hw/rtl/eira_pkg.sv =====
// ----------------------------------------------------------------------------
// eira_pkg
// Shared types and codes for the exact integer and rational ALU.
// ----------------------------------------------------------------------------
package eira_pkg;

    localparam int DATA_W = 64;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_LT  = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_DIVZ  = 2'd1;
    localparam logic [1:0] STAT_UNSUP = 2'd2;

    localparam logic KIND_INT = 1'b0;
    localparam logic KIND_RAT = 1'b1;

    typedef struct packed {
        logic [2:0]               req_type;
        logic                     left_kind;
        logic signed [DATA_W-1:0] left_value;
        logic signed [DATA_W-1:0] left_den;
        logic                     right_kind;
        logic signed [DATA_W-1:0] right_value;
        logic signed [DATA_W-1:0] right_den;
    } eira_req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic                     result_kind;
        logic signed [DATA_W-1:0] result_value;
        logic signed [DATA_W-1:0] result_den;
        logic                     is_less;
    } eira_rsp_t;

    typedef enum logic [1:0] {
        UOP_MUL,
        UOP_DIV,
        UOP_GCD
    } eira_uop_t;

    typedef struct packed {
        logic      start;
        eira_uop_t op;
    } eira_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_GCD,
        ST_DIVN,
        ST_DIVD,
        ST_FIN
    } eira_state_t;

endpackage

// ===== hw/rtl/exact_int_rational_alu.sv =====
// ----------------------------------------------------------------------------
// exact_int_rational_alu
// Exact integer and rational arithmetic with gcd reduction.
// ----------------------------------------------------------------------------
// Add, subtract, less-than and every error case are settled when the
// request is taken and pass through the finish state into the output
// register. Integer multiply, divide and mixed multiply run on one shared
// unit: a VALUE_WIDTH-step multiply or divide, then for a divide with a
// remainder or a mixed multiply a binary gcd and two VALUE_WIDTH-step
// reducing divides. Requests are stalled while one is in work; a finished
// response waits in an output register.
module exact_int_rational_alu
    import eira_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  eira_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output eira_rsp_t rsp
);

    localparam int W = VALUE_WIDTH;

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (W)'(-v) : v;
    endfunction

    function automatic logic [W-1:0] apply_sign(input logic [W-1:0] q, input logic neg);
        return neg ? (W)'(-q) : q;
    endfunction

    eira_state_t  state_reg, state_next;
    logic         rsp_valid_reg, rsp_valid_next;
    eira_rsp_t    rsp_reg, rsp_next;
    logic         mix_reg, mix_next;
    logic [W-1:0] n_reg, n_next;
    logic [W-1:0] d_reg, d_next;
    logic [W-1:0] g_reg, g_next;
    logic [1:0]   st_reg, st_next;
    logic         kind_reg, kind_next;
    logic [W-1:0] val_reg, val_next;
    logic [W-1:0] den_reg, den_next;
    logic         less_reg, less_next;

    eira_cmd_t    cmd;
    logic [W-1:0] ua, ub;
    logic         u_done;
    logic [W-1:0] u_quo, u_acc;

    logic [W-1:0] lv, ld, rv, rd, den_sel, dq;
    logic         lrat, rrat, both_int;

    eira_unit #(.W(W)) u_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .a     (ua),
        .b     (ub),
        .done  (u_done),
        .quo   (u_quo),
        .acc   (u_acc)
    );

    assign lv       = req.left_value[W-1:0];
    assign ld       = req.left_den[W-1:0];
    assign rv       = req.right_value[W-1:0];
    assign rd       = req.right_den[W-1:0];
    assign lrat     = req.left_kind;
    assign rrat     = req.right_kind;
    assign both_int = !lrat && !rrat;
    assign den_sel  = lrat ? ld : rd;
    assign dq       = apply_sign(u_quo, d_reg[W-1]);

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        mix_next       = mix_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        g_next         = g_reg;
        st_next        = st_reg;
        kind_next      = kind_reg;
        val_next       = val_reg;
        den_next       = den_reg;
        less_next      = less_reg;
        cmd.start      = 1'b0;
        cmd.op         = UOP_MUL;
        ua             = '0;
        ub             = '0;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    st_next    = STAT_OK;
                    kind_next  = KIND_INT;
                    val_next   = '0;
                    den_next   = W'(1);
                    less_next  = 1'b0;
                    state_next = ST_FIN;
                    case (req.req_type)
                        OP_ADD, OP_SUB, OP_LT:
                        begin
                            if (!both_int)
                            begin
                                st_next = STAT_UNSUP;
                            end
                            else if (req.req_type == OP_ADD)
                            begin
                                val_next = lv + rv;
                            end
                            else if (req.req_type == OP_SUB)
                            begin
                                val_next = lv - rv;
                            end
                            else
                            begin
                                less_next = $signed(lv) < $signed(rv);
                            end
                        end
                        OP_DIV:
                        begin
                            if (!both_int)
                            begin
                                st_next = STAT_UNSUP;
                            end
                            else if (rv == '0)
                            begin
                                st_next = STAT_DIVZ;
                            end
                            else
                            begin
                                n_next     = lv;
                                d_next     = rv;
                                cmd.start  = 1'b1;
                                cmd.op     = UOP_DIV;
                                ua         = mag(lv);
                                ub         = mag(rv);
                                state_next = ST_DIV;
                            end
                        end
                        OP_MUL:
                        begin
                            if (lrat && rrat)
                            begin
                                st_next = STAT_UNSUP;
                            end
                            else if (!both_int && den_sel == '0)
                            begin
                                st_next = STAT_DIVZ;
                            end
                            else
                            begin
                                mix_next   = !both_int;
                                d_next     = den_sel;
                                cmd.start  = 1'b1;
                                cmd.op     = UOP_MUL;
                                ua         = lv;
                                ub         = rv;
                                state_next = ST_MUL;
                            end
                        end
                        default:
                        begin
                            st_next = STAT_UNSUP;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                if (u_done)
                begin
                    if (!mix_reg)
                    begin
                        val_next   = u_acc;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        n_next     = u_acc;
                        cmd.start  = 1'b1;
                        cmd.op     = UOP_GCD;
                        ua         = mag(u_acc);
                        ub         = mag(d_reg);
                        state_next = ST_GCD;
                    end
                end
            end
            ST_DIV:
            begin
                if (u_done)
                begin
                    if (u_acc == '0)
                    begin
                        val_next   = apply_sign(u_quo, n_reg[W-1] ^ d_reg[W-1]);
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        cmd.op     = UOP_GCD;
                        ua         = mag(n_reg);
                        ub         = mag(d_reg);
                        state_next = ST_GCD;
                    end
                end
            end
            ST_GCD:
            begin
                if (u_done)
                begin
                    g_next     = u_acc;
                    cmd.start  = 1'b1;
                    cmd.op     = UOP_DIV;
                    ua         = mag(n_reg);
                    ub         = u_acc;
                    state_next = ST_DIVN;
                end
            end
            ST_DIVN:
            begin
                if (u_done)
                begin
                    n_next     = apply_sign(u_quo, n_reg[W-1]);
                    cmd.start  = 1'b1;
                    cmd.op     = UOP_DIV;
                    ua         = mag(d_reg);
                    ub         = g_reg;
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD:
            begin
                if (u_done)
                begin
                    val_next   = n_reg;
                    den_next   = dq;
                    kind_next  = (dq == W'(1)) ? KIND_INT : KIND_RAT;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status       = st_reg;
                    rsp_next.result_kind  = kind_reg;
                    rsp_next.result_value = DATA_W'($signed(val_reg));
                    rsp_next.result_den   = DATA_W'($signed(den_reg));
                    rsp_next.is_less      = less_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        mix_reg  <= mix_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        g_reg    <= g_next;
        st_reg   <= st_next;
        kind_reg <= kind_next;
        val_reg  <= val_next;
        den_reg  <= den_next;
        less_reg <= less_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_rsp_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_FIN)
        else $error("response raised outside finish state");

    a_done_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        u_done |-> (state_reg == ST_MUL || state_reg == ST_DIV || state_reg == ST_GCD ||
                    state_reg == ST_DIVN || state_reg == ST_DIVD))
        else $error("unit completion with no operation pending");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status != STAT_OK |->
            rsp_reg.result_value == '0 && rsp_reg.result_den == DATA_W'(1))
        else $error("error response carries a value");

endmodule

// ===== hw/rtl/eira_unit.sv =====
// ----------------------------------------------------------------------------
// eira_unit
// Shared iterative unit: shift-add multiply, restoring divide and binary gcd
// over one adder/subtractor, one step per cycle.
// ----------------------------------------------------------------------------
module eira_unit
    import eira_pkg::*;
#(
    parameter int W = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  eira_cmd_t    cmd,
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic         done,
    output logic [W-1:0] quo,
    output logic [W-1:0] acc
);

    localparam int CW = $clog2(W + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    eira_uop_t     op_reg, op_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  x_reg, x_next;
    logic [W-1:0]  y_reg, y_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] k_reg, k_next;

    logic [W:0]    t;
    logic [W:0]    au_a, au_b;
    logic          au_sub;
    logic [W+1:0]  au_sum;
    logic          ge;

    always_comb
    begin
        t = {acc_reg, x_reg[W-1]};
        case (op_reg)
            UOP_MUL:
            begin
                au_a   = {1'b0, acc_reg};
                au_b   = {1'b0, x_reg};
                au_sub = 1'b0;
            end
            UOP_DIV:
            begin
                au_a   = t;
                au_b   = {1'b0, y_reg};
                au_sub = 1'b1;
            end
            default:
            begin
                au_a   = {1'b0, acc_reg};
                au_b   = {1'b0, y_reg};
                au_sub = 1'b1;
            end
        endcase
        au_sum = {1'b0, au_a} + {1'b0, (au_sub ? ~au_b : au_b)} + (W+2)'(au_sub);
        ge     = au_sum[W+1];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        cnt_next  = cnt_reg;
        k_next    = k_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            op_next   = cmd.op;
            cnt_next  = CW'(W);
            k_next    = '0;
            acc_next  = (cmd.op == UOP_GCD) ? a : '0;
            x_next    = a;
            y_next    = b;
        end
        else if (busy_reg)
        begin
            case (op_reg)
                UOP_MUL:
                begin
                    if (y_reg[0])
                    begin
                        acc_next = au_sum[W-1:0];
                    end
                    x_next   = x_reg << 1;
                    y_next   = y_reg >> 1;
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                UOP_DIV:
                begin
                    acc_next = ge ? au_sum[W-1:0] : t[W-1:0];
                    x_next   = {x_reg[W-2:0], ge};
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == CW'(1))
                    begin
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                end
                default:
                begin
                    if (acc_reg == '0 || y_reg == '0)
                    begin
                        acc_next  = ((acc_reg == '0) ? y_reg : acc_reg) << k_reg;
                        busy_next = 1'b0;
                        done_next = 1'b1;
                    end
                    else if (!acc_reg[0] && !y_reg[0])
                    begin
                        acc_next = acc_reg >> 1;
                        y_next   = y_reg >> 1;
                        k_next   = k_reg + 1'b1;
                    end
                    else if (!acc_reg[0])
                    begin
                        acc_next = acc_reg >> 1;
                    end
                    else if (!y_reg[0])
                    begin
                        y_next = y_reg >> 1;
                    end
                    else if (ge)
                    begin
                        acc_next = au_sum[W-1:0];
                    end
                    else
                    begin
                        acc_next = y_reg;
                        y_next   = acc_reg;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= UOP_MUL;
            cnt_reg  <= '0;
            k_reg    <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
            k_reg    <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign done = done_reg;
    assign quo  = x_reg;
    assign acc  = acc_reg;

endmodule
